[sv/chf_pkg.sv]
// Shared widths, constants, CORDIC angle table and LED sector lookup for the compass filter.
package chf_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int FILT_W      = 18;
  localparam int HEAD_W      = 15;
  localparam int LED_W       = 4;
  localparam int IN_DATA_W   = 48;
  localparam int OUT_DATA_W  = 104;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  // CORDIC datapath: samples scaled by 2^PRESCALE, angle in 2^-14 degree
  localparam int CORDIC_W    = 40;
  localparam int ANGLE_W     = 25;
  localparam int ATAN_W      = 20;
  localparam int ITERS       = 16;
  localparam int ITER_W      = 4;
  localparam int PRESCALE    = 20;
  localparam int ROUND_SHIFT = 8;

  // reciprocal multiply for the window average divide
  localparam int RECIP_SHIFT = 26;

  localparam int FULL_TURN = 23040;
  localparam logic signed [ANGLE_W-1:0] HALF_TURN_Z = 25'sd2949120;

  localparam logic [ATAN_W-1:0] ATAN_LUT [ITERS] = '{
    20'd737280, 20'd435242, 20'd229970, 20'd116736,
    20'd58595,  20'd29326,  20'd14667,  20'd7334,
    20'd3667,   20'd1833,   20'd917,    20'd458,
    20'd229,    20'd115,    20'd57,     20'd29
  };

  localparam logic [LED_W-1:0] LED_N  = 4'b0001;
  localparam logic [LED_W-1:0] LED_NE = 4'b0011;
  localparam logic [LED_W-1:0] LED_E  = 4'b0010;
  localparam logic [LED_W-1:0] LED_SE = 4'b0110;
  localparam logic [LED_W-1:0] LED_S  = 4'b0100;
  localparam logic [LED_W-1:0] LED_SW = 4'b1100;
  localparam logic [LED_W-1:0] LED_W_ = 4'b1000;
  localparam logic [LED_W-1:0] LED_NW = 4'b1001;

  localparam logic [HEAD_W-1:0] SEC_30  = 15'd1920;
  localparam logic [HEAD_W-1:0] SEC_60  = 15'd3840;
  localparam logic [HEAD_W-1:0] SEC_120 = 15'd7680;
  localparam logic [HEAD_W-1:0] SEC_150 = 15'd9600;
  localparam logic [HEAD_W-1:0] SEC_210 = 15'd13440;
  localparam logic [HEAD_W-1:0] SEC_240 = 15'd15360;
  localparam logic [HEAD_W-1:0] SEC_300 = 15'd19200;
  localparam logic [HEAD_W-1:0] SEC_330 = 15'd21120;

  // exact sector limits keep the previous pattern
  function automatic logic [LED_W-1:0] sector_pattern(input logic [HEAD_W-1:0] h,
                                                      input logic [LED_W-1:0]  prev);
    logic [LED_W-1:0] p;
    p = prev;
    if (h > SEC_330 || h < SEC_30)        p = LED_N;
    else if (h > SEC_30  && h < SEC_60)   p = LED_NE;
    else if (h > SEC_60  && h < SEC_120)  p = LED_E;
    else if (h > SEC_120 && h < SEC_150)  p = LED_SE;
    else if (h > SEC_150 && h < SEC_210)  p = LED_S;
    else if (h > SEC_210 && h < SEC_240)  p = LED_SW;
    else if (h > SEC_240 && h < SEC_300)  p = LED_W_;
    else if (h > SEC_300 && h < SEC_330)  p = LED_NW;
    return p;
  endfunction

endpackage

[sv/chf_window.sv]
// Sample windows with running sums and the quarter-unit average by reciprocal multiply.
module chf_window
  import chf_pkg::*;
#(
  parameter int WINDOW_DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  logic                     read_ok,
  input  logic signed [SAMPLE_W-1:0] sample_x,
  input  logic signed [SAMPLE_W-1:0] sample_y,
  output logic                     avg_vld,
  output logic signed [FILT_W-1:0] filt_x,
  output logic signed [FILT_W-1:0] filt_y
);

  localparam int SUM_W  = SAMPLE_W + 1 + $clog2(WINDOW_DEPTH);
  localparam int QW     = SUM_W + 2;
  localparam int PROD_W = QW + RECIP_SHIFT;
  localparam logic [RECIP_SHIFT-1:0] RECIP =
    RECIP_SHIFT'((2**RECIP_SHIFT + WINDOW_DEPTH - 1) / WINDOW_DEPTH);
  localparam logic [QW-1:0] BIAS = QW'(WINDOW_DEPTH - 1);

  logic signed [SAMPLE_W-1:0] xw_r [WINDOW_DEPTH];
  logic signed [SAMPLE_W-1:0] yw_r [WINDOW_DEPTH];
  logic signed [SAMPLE_W-1:0] nx, ny;
  logic signed [SUM_W-1:0]    xsum_r, xsum_nxt, ysum_r, ysum_nxt;
  logic [QW-1:0]              mag_x, mag_y, qx, qy;
  logic [PROD_W-1:0]          prodx_r, prody_r;
  logic                       negx_r, negy_r;
  logic                       s1_r, s2_r, vld_r;
  logic signed [FILT_W-1:0]   fx_r, fy_r;

  // floor division needs |4*sum| + (depth-1) for negative sums
  function automatic logic [QW-1:0] mag_bias(input logic signed [SUM_W-1:0] s);
    logic [QW-1:0] u;
    u = {s, 2'b00};
    return s[SUM_W-1] ? ((-u) + BIAS) : u;
  endfunction

  assign nx = read_ok ? sample_x : xw_r[0];
  assign ny = read_ok ? sample_y : yw_r[0];

  assign xsum_nxt = xsum_r + SUM_W'(nx) - SUM_W'(xw_r[WINDOW_DEPTH-1]);
  assign ysum_nxt = ysum_r + SUM_W'(ny) - SUM_W'(yw_r[WINDOW_DEPTH-1]);

  assign mag_x = mag_bias(xsum_r);
  assign mag_y = mag_bias(ysum_r);

  assign qx = prodx_r[PROD_W-1:RECIP_SHIFT];
  assign qy = prody_r[PROD_W-1:RECIP_SHIFT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < WINDOW_DEPTH; k++) begin
        xw_r[k] <= '0;
        yw_r[k] <= '0;
      end
      xsum_r <= '0;
      ysum_r <= '0;
      s1_r   <= 1'b0;
      s2_r   <= 1'b0;
      vld_r  <= 1'b0;
    end else begin
      s1_r  <= push;
      s2_r  <= s1_r;
      vld_r <= s2_r;
      if (push) begin
        for (int k = WINDOW_DEPTH - 1; k > 0; k--) begin
          xw_r[k] <= xw_r[k-1];
          yw_r[k] <= yw_r[k-1];
        end
        xw_r[0] <= nx;
        yw_r[0] <= ny;
        xsum_r  <= xsum_nxt;
        ysum_r  <= ysum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_r) begin
      prodx_r <= PROD_W'(mag_x) * PROD_W'(RECIP);
      prody_r <= PROD_W'(mag_y) * PROD_W'(RECIP);
      negx_r  <= xsum_r[SUM_W-1];
      negy_r  <= ysum_r[SUM_W-1];
    end
    if (s2_r) begin
      fx_r <= FILT_W'(negx_r ? (-qx) : qx);
      fy_r <= FILT_W'(negy_r ? (-qy) : qy);
    end
  end

  assign avg_vld = vld_r;
  assign filt_x  = fx_r;
  assign filt_y  = fy_r;

endmodule

[sv/chf_cordic.sv]
// Iterative vectoring CORDIC: one rotation step per cycle, then rounding and wrap to 0..360 deg.
module chf_cordic
  import chf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [FILT_W-1:0] fx,
  input  logic signed [FILT_W-1:0] fy,
  output logic                     busy,
  output logic                     done,
  output logic [HEAD_W-1:0]        heading
);

  localparam int HS_W = ANGLE_W - ROUND_SHIFT;

  logic signed [CORDIC_W-1:0] x_r, x_nxt, y_r, y_nxt, xs, ys, x0, y0;
  logic signed [ANGLE_W-1:0]  z_r, z_nxt, a_step, z_rnd;
  logic [ITER_W-1:0]          i_r, i_nxt;
  logic                       busy_r, busy_nxt, fin_r, fin_nxt, zero_r, zero_nxt, done_r;
  logic signed [HS_W-1:0]     hs, h_adj;
  logic [HEAD_W-1:0]          head_r;

  assign x0 = {{(CORDIC_W-FILT_W-PRESCALE){fx[FILT_W-1]}}, fx, {PRESCALE{1'b0}}};
  assign y0 = {{(CORDIC_W-FILT_W-PRESCALE){fy[FILT_W-1]}}, fy, {PRESCALE{1'b0}}};

  assign xs     = x_r >>> i_r;
  assign ys     = y_r >>> i_r;
  assign a_step = $signed({{(ANGLE_W-ATAN_W){1'b0}}, ATAN_LUT[i_r]});

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    i_nxt    = i_r;
    busy_nxt = busy_r;
    fin_nxt  = 1'b0;
    zero_nxt = zero_r;
    if (start) begin
      zero_nxt = (fx == '0) && (fy == '0);
      i_nxt    = '0;
      busy_nxt = 1'b1;
      // left half plane: rotate by 180 deg first
      if (fx[FILT_W-1]) begin
        x_nxt = -x0;
        y_nxt = -y0;
        z_nxt = HALF_TURN_Z;
      end else begin
        x_nxt = x0;
        y_nxt = y0;
        z_nxt = '0;
      end
    end else if (busy_r) begin
      if (!y_r[CORDIC_W-1]) begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + a_step;
      end else begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - a_step;
      end
      i_nxt = i_r + 1'b1;
      if (i_r == ITER_W'(ITERS - 1)) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end
  end

  assign z_rnd = z_r + ANGLE_W'(1 << (ROUND_SHIFT - 1));
  assign hs    = z_rnd[ANGLE_W-1:ROUND_SHIFT];

  always_comb begin
    h_adj = hs;
    if (hs[HS_W-1])
      h_adj = hs + HS_W'(FULL_TURN);
    else if (hs >= HS_W'(FULL_TURN))
      h_adj = hs - HS_W'(FULL_TURN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      i_r    <= '0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
      done_r <= fin_r;
      i_r    <= i_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    zero_r <= zero_nxt;
    if (fin_r)
      head_r <= zero_r ? '0 : h_adj[HEAD_W-1:0];
  end

  assign busy    = busy_r;
  assign done    = done_r;
  assign heading = head_r;

endmodule

[sv/compass_heading_filter.sv]
// Compass heading filter top level: register port, sequencer and output register.
//
// Input stream carries one magnetometer sample (x, y, z) with a read-ok flag
// in in_tuser; a failed read repeats the newest stored x and y. Each request
// yields exactly one result on the output stream: the raw sample, the error
// flag, the quarter-unit window averages, the heading in 1/64 degree and the
// four-LED sector pattern.
// After the input request is taken, out_tvalid rises once these have run in
// order: the window update and reciprocal-multiply average, the shared CORDIC
// step unit, then rounding, result handoff and output load.
// in_tready is high only while the sequencer is idle, so a new request is
// taken only once the previous result has left the sequencer.
// A finished result sits in the output register; the next request is taken
// while it waits. If out_tready stays low, the following result holds in
// the sequencer until the output register frees.
// Reset (synchronous, rst_n low) clears the windows, the LED pattern and
// orientation_mode (APB offset 0x0, bit 0).
module compass_heading_filter
  import chf_pkg::*;
#(
  parameter int WINDOW_DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,     // sample_x, sample_y, sample_z
  input  logic [0:0]            in_tuser,     // read_ok
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,    // raw_x, raw_y, raw_z, filtered_x,
                                              // filtered_y, heading, led_pattern, pad
  output logic [0:0]            out_tuser,    // read_error
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_BUSY = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic REG_MODE = 1'b0;

  logic [1:0]               state_r, state_nxt;
  logic                     mode_r;
  logic [LED_W-1:0]         pat_r, pat_nxt;
  logic [IN_DATA_W-1:0]     raw_r;
  logic                     err_r;
  logic                     out_vld_r;
  logic [OUT_DATA_W-1:0]    out_data_r;
  logic                     out_user_r;
  logic                     accept, load, cfg_wr;
  logic                     avg_vld, rot_busy, rot_done;
  logic signed [FILT_W-1:0] filt_x, filt_y;
  logic [HEAD_W-1:0]        heading;

  assign accept = in_tvalid && in_tready;
  assign load   = (state_r == ST_DONE) && (!out_vld_r || out_tready);
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_MODE) ? CFG_DATA_W'(mode_r) : '0;

  chf_window #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (accept),
    .read_ok  (in_tuser[0]),
    .sample_x (in_tdata[SAMPLE_W-1:0]),
    .sample_y (in_tdata[2*SAMPLE_W-1:SAMPLE_W]),
    .avg_vld  (avg_vld),
    .filt_x   (filt_x),
    .filt_y   (filt_y)
  );

  chf_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (avg_vld),
    .fx      (filt_x),
    .fy      (filt_y),
    .busy    (rot_busy),
    .done    (rot_done),
    .heading (heading)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept)   state_nxt = ST_BUSY;
      ST_BUSY: if (rot_done) state_nxt = ST_DONE;
      ST_DONE: if (load)     state_nxt = ST_IDLE;
      default:               state_nxt = ST_IDLE;
    endcase
  end

  assign in_tready = (state_r == ST_IDLE);
  assign pat_nxt   = mode_r ? sector_pattern(heading, pat_r) : pat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      mode_r    <= 1'b0;
      pat_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr && cfg_paddr[2] == REG_MODE)
        mode_r <= cfg_pwdata[0];
      if (load) begin
        pat_r     <= pat_nxt;
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      raw_r <= in_tdata;
      err_r <= !in_tuser[0];
    end
    if (load) begin
      out_data_r <= {1'b0, pat_nxt, heading, filt_y, filt_x, raw_r};
      out_user_r <= err_r;
    end
  end

  assign out_tvalid   = out_vld_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_user_r;

`ifndef SYNTH
  a_no_double_take: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("input taken while an item is in flight");

  a_done_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    rot_done |-> (state_r == ST_BUSY) && !rot_busy)
    else $error("CORDIC finished outside the busy state");

  a_led_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (load && !mode_r) |=> $stable(pat_r))
    else $error("LED pattern changed in raw data mode");
`endif

endmodule

[dv/compass_heading_filter_test.sv]
// Self-checking testbench for compass_heading_filter: streams magnetometer samples, checks every result.
`timescale 1ns / 1ps

module compass_heading_filter_test;

  localparam int WIN_DEPTH   = 4;
  localparam int QUIET_LIMIT = 2000;
  localparam int FULL_CIRCLE = 23040;

  // register map
  localparam logic [chf_pkg::CFG_ADDR_W-1:0] ADDR_ORIENT = 3'd0;
  localparam logic [chf_pkg::CFG_ADDR_W-1:0] ADDR_SPARE  = 3'd4;

  // sector limits in 1/64 degree
  localparam int DEG30  = 1920;
  localparam int DEG60  = 3840;
  localparam int DEG120 = 7680;
  localparam int DEG150 = 9600;
  localparam int DEG210 = 13440;
  localparam int DEG240 = 15360;
  localparam int DEG300 = 19200;
  localparam int DEG330 = 21120;

  localparam logic [3:0] LEDS_OFF = 4'b0000;
  localparam logic [3:0] LEDS_N   = 4'b0001;
  localparam logic [3:0] LEDS_NE  = 4'b0011;
  localparam logic [3:0] LEDS_E   = 4'b0010;
  localparam logic [3:0] LEDS_SE  = 4'b0110;
  localparam logic [3:0] LEDS_S   = 4'b0100;
  localparam logic [3:0] LEDS_SW  = 4'b1100;
  localparam logic [3:0] LEDS_W   = 4'b1000;
  localparam logic [3:0] LEDS_NW  = 4'b1001;

  typedef struct {
    logic [15:0] raw_x, raw_y, raw_z;
    logic        err;
    logic [17:0] filt_x, filt_y;
    logic [14:0] heading;
    logic [3:0]  leds;
  } reading_t;

  typedef struct {
    bit          mode;
    logic [15:0] x, y, z;
    bit          ok;
    int          bnd;
    bit          typed;
    int          fx, fy, h, leds;
  } step_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [chf_pkg::IN_DATA_W-1:0] in_tdata = '0;   // sample_x, sample_y, sample_z
  logic [0:0] in_tuser = '0;                      // read_ok
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [chf_pkg::OUT_DATA_W-1:0] out_tdata;      // raw_x, raw_y, raw_z, filtered_x,
                                                  // filtered_y, heading, led_pattern, pad
  logic [0:0] out_tuser;                          // read_error
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [chf_pkg::CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [chf_pkg::CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [chf_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  compass_heading_filter #(.WINDOW_DEPTH(WIN_DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  int         x_hist [WIN_DEPTH];
  int         y_hist [WIN_DEPTH];
  logic [3:0] led_state = LEDS_OFF;
  bit         orient_mode = 1'b0;

  reading_t    pending_readings [$];
  step_row_t   plan [$];
  logic [15:0] lim_x [8];
  logic [15:0] lim_y [8];

  int  mismatches = 0;
  int  results_seen = 0;
  int  items_sent = 0;
  int  failed_reads = 0;
  int  limit_hits = 0;
  int  mode_writes = 0;
  int  quiet_cycles = 0;
  bit  steady = 1'b0;

  function automatic longint arc_step(int i);
    case (i)
      0:  return 737280;
      1:  return 435242;
      2:  return 229970;
      3:  return 116736;
      4:  return 58595;
      5:  return 29326;
      6:  return 14667;
      7:  return 7334;
      8:  return 3667;
      9:  return 1833;
      10: return 917;
      11: return 458;
      12: return 229;
      13: return 115;
      14: return 57;
      default: return 29;
    endcase
  endfunction

  // vectoring CORDIC; angle accumulates in 2^-14 degree
  function automatic logic [14:0] cordic_heading(int fx, int fy);
    longint cx, cy, cz, nx, hh;
    int i;
    if (fx == 0 && fy == 0) return '0;
    cx = longint'(fx) * 1048576;
    cy = longint'(fy) * 1048576;
    cz = 0;
    if (cx < 0) begin
      cx = -cx;
      cy = -cy;
      cz = 180 * 16384;
    end
    for (i = 0; i < 16; i++) begin
      if (cy >= 0) begin
        nx = cx + (cy >>> i);
        cy = cy - (cx >>> i);
        cz += arc_step(i);
      end else begin
        nx = cx - (cy >>> i);
        cy = cy + (cx >>> i);
        cz -= arc_step(i);
      end
      cx = nx;
    end
    hh = (cz + 128) >>> 8;
    if (hh < 0) hh += FULL_CIRCLE;
    if (hh >= FULL_CIRCLE) hh -= FULL_CIRCLE;
    return hh[14:0];
  endfunction

  // an exact limit holds the previous pattern
  function automatic logic [3:0] led_sector(int h, logic [3:0] prev);
    if (h > DEG330 || h < DEG30) return LEDS_N;
    if (h > DEG30 && h < DEG60) return LEDS_NE;
    if (h > DEG60 && h < DEG120) return LEDS_E;
    if (h > DEG120 && h < DEG150) return LEDS_SE;
    if (h > DEG150 && h < DEG210) return LEDS_S;
    if (h > DEG210 && h < DEG240) return LEDS_SW;
    if (h > DEG240 && h < DEG300) return LEDS_W;
    if (h > DEG300 && h < DEG330) return LEDS_NW;
    return prev;
  endfunction

  function automatic int sector_limit(int k);
    case (k)
      0: return DEG30;
      1: return DEG60;
      2: return DEG120;
      3: return DEG150;
      4: return DEG210;
      5: return DEG240;
      6: return DEG300;
      default: return DEG330;
    endcase
  endfunction

  // floor of 4 * sum / depth
  function automatic int quarter_avg(int sum);
    int s;
    s = sum * 4;
    if (s >= 0) return s / WIN_DEPTH;
    return -((-s + WIN_DEPTH - 1) / WIN_DEPTH);
  endfunction

  function automatic reading_t predict_reading(logic [15:0] sx, logic [15:0] sy,
                                               logic [15:0] sz, bit ok);
    reading_t r;
    int k, sum_x, sum_y, fx, fy, nx, ny;
    logic [14:0] h;
    nx = ok ? int'($signed(sx)) : x_hist[0];
    ny = ok ? int'($signed(sy)) : y_hist[0];
    for (k = WIN_DEPTH - 1; k > 0; k--) begin
      x_hist[k] = x_hist[k - 1];
      y_hist[k] = y_hist[k - 1];
    end
    x_hist[0] = nx;
    y_hist[0] = ny;
    sum_x = 0;
    sum_y = 0;
    for (k = 0; k < WIN_DEPTH; k++) begin
      sum_x += x_hist[k];
      sum_y += y_hist[k];
    end
    fx = quarter_avg(sum_x);
    fy = quarter_avg(sum_y);
    h = cordic_heading(fx, fy);
    if (orient_mode) led_state = led_sector(h, led_state);
    r.raw_x = sx;
    r.raw_y = sy;
    r.raw_z = sz;
    r.err = !ok;
    r.filt_x = fx[17:0];
    r.filt_y = fy[17:0];
    r.heading = h;
    r.leds = led_state;
    return r;
  endfunction

  // scan along a line for a sample whose steady window lands exactly on each sector limit
  function automatic void find_sector_limits();
    int k, m, t, px, py;
    bit hit;
    for (k = 0; k < 8; k++) begin
      hit = 1'b0;
      lim_x[k] = '0;
      lim_y[k] = '0;
      for (m = 4000; m < 4040 && !hit; m++) begin
        for (t = m / 4; t <= m && !hit; t++) begin
          case (k)
            0: begin px = m;  py = t;  end
            1: begin px = t;  py = m;  end
            2: begin px = -t; py = m;  end
            3: begin px = -m; py = t;  end
            4: begin px = -m; py = -t; end
            5: begin px = -t; py = -m; end
            6: begin px = t;  py = -m; end
            default: begin px = m; py = -t; end
          endcase
          if (cordic_heading(4 * px, 4 * py) == sector_limit(k)) begin
            hit = 1'b1;
            lim_x[k] = px[15:0];
            lim_y[k] = py[15:0];
          end
        end
      end
    end
  endfunction

  function automatic void add_row(bit m, logic [15:0] x, logic [15:0] y, logic [15:0] z,
                                  bit ok, int bnd, bit typed, int fx, int fy, int h,
                                  int leds);
    step_row_t r;
    r.mode = m;
    r.x = x;
    r.y = y;
    r.z = z;
    r.ok = ok;
    r.bnd = bnd;
    r.typed = typed;
    r.fx = fx;
    r.fy = fy;
    r.h = h;
    r.leds = leds;
    plan.push_back(r);
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 50) $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input int idx,
                             input logic signed [31:0] got, input logic signed [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %0d, expected %0d", idx, name, got, want));
  endtask

  task automatic cfg_write(input logic [chf_pkg::CFG_ADDR_W-1:0] addr,
                           input logic [chf_pkg::CFG_DATA_W-1:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_read(input logic [chf_pkg::CFG_ADDR_W-1:0] addr,
                          output logic [chf_pkg::CFG_DATA_W-1:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= addr;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    data = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // drain, switch mode (junk in the upper bits), poke an unmapped register, read back
  task automatic apply_mode(input bit m);
    logic [chf_pkg::CFG_DATA_W-1:0] rd;
    in_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    cfg_write(ADDR_ORIENT, {31'($urandom), m});
    orient_mode = m;
    mode_writes++;
    cfg_write(ADDR_SPARE, $urandom);
    cfg_read(ADDR_ORIENT, rd);
    if (rd !== {31'b0, m})
      report_mismatch($sformatf("orientation_mode read back %0h, expected %0d", rd, m));
  endtask

  // hold valid until taken; leave it high unless a gap follows
  task automatic issue_row(input step_row_t r);
    reading_t want;
    in_tdata <= {r.z, r.y, r.x};
    in_tuser <= r.ok;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    want = predict_reading(r.x, r.y, r.z, r.ok);
    if (r.typed) begin
      want.filt_x = r.fx[17:0];
      want.filt_y = r.fy[17:0];
      want.heading = r.h[14:0];
      want.leds = r.leds[3:0];
    end
    if (want.heading inside {DEG30, DEG60, DEG120, DEG150, DEG210, DEG240, DEG300, DEG330})
      limit_hits++;
    if (!r.ok) failed_reads++;
    pending_readings.push_back(want);
    items_sent++;
    steady = (items_sent >= 400 && items_sent < 650);
    if (!steady && $urandom_range(0, 99) < 20) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  endtask

  always @(posedge clk) out_tready <= steady || ($urandom_range(0, 99) >= 20);

  always @(posedge clk) begin : result_check
    reading_t seen, want;
    if (rst_n && out_tvalid && out_tready) begin
      seen.raw_x = out_tdata[15:0];
      seen.raw_y = out_tdata[31:16];
      seen.raw_z = out_tdata[47:32];
      seen.filt_x = out_tdata[65:48];
      seen.filt_y = out_tdata[83:66];
      seen.heading = out_tdata[98:84];
      seen.leds = out_tdata[102:99];
      seen.err = out_tuser[0];
      if (pending_readings.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing pending", results_seen));
      end else begin
        want = pending_readings.pop_front();
        check_field("raw_x", results_seen, $signed(seen.raw_x), $signed(want.raw_x));
        check_field("raw_y", results_seen, $signed(seen.raw_y), $signed(want.raw_y));
        check_field("raw_z", results_seen, $signed(seen.raw_z), $signed(want.raw_z));
        check_field("read_error", results_seen, {31'b0, seen.err}, {31'b0, want.err});
        check_field("filtered_x", results_seen, $signed(seen.filt_x), $signed(want.filt_x));
        check_field("filtered_y", results_seen, $signed(seen.filt_y), $signed(want.filt_y));
        check_field("heading", results_seen, {17'b0, seen.heading}, {17'b0, want.heading});
        check_field("led_pattern", results_seen, {28'b0, seen.leds}, {28'b0, want.leds});
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("Watchdog: no traffic for %0d cycles, %0d results pending",
               QUIET_LIMIT, pending_readings.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    step_row_t   r;
    logic [chf_pkg::CFG_DATA_W-1:0] rd;
    int          phase, phase_start, kind, reps, k, sel;
    logic [15:0] bx, by;

    find_sector_limits();

    // raw mode: failed read straight after reset, extremes, a failed read after a full window
    add_row(0, 16'h1234, 16'hABCD, 16'h7FFF, 0, -1, 1, 0, 0, 0, LEDS_OFF);
    add_row(0, 16'h7FFF, 16'h0000, 16'h8000, 1, -1, 0, 0, 0, 0, 0);
    repeat (4) add_row(0, 16'h8000, 16'h8000, 16'h0000, 1, -1, 0, 0, 0, 0, 0);
    add_row(0, 16'h5555, 16'hAAAA, 16'h7FFF, 0, -1, 0, 0, 0, 0, 0);
    // orientation mode: window back to zero gives heading 0 and north
    repeat (3) add_row(1, 16'h0000, 16'h0000, 16'h1234, 1, -1, 0, 0, 0, 0, 0);
    add_row(1, 16'h0000, 16'h0000, 16'h1234, 1, -1, 1, 0, 0, 0, LEDS_N);
    add_row(1, 16'h8000, 16'h7FFF, 16'hFFFF, 0, -1, 1, 0, 0, 0, LEDS_N);
    // zero x, nonzero y
    add_row(1, 16'h0000, 16'h7FFF, 16'h2222, 1, -1, 0, 0, 0, 0, 0);
    repeat (2) add_row(1, 16'h7FFF, 16'h7FFF, 16'h0001, 1, -1, 0, 0, 0, 0, 0);
    // settle on an exact sector limit: pattern must hold
    add_row(1, 16'h0000, 16'h0000, 16'h0F0F, 1, 0, 0, 0, 0, 0, 0);
    add_row(1, 16'h0000, 16'h0000, 16'hF0F0, 1, 0, 0, 0, 0, 0, 0);
    add_row(1, 16'h0000, 16'h0000, 16'h00FF, 1, 0, 0, 0, 0, 0, 0);
    add_row(1, 16'h0000, 16'h0000, 16'hFF00, 1, 0, 0, 0, 0, 0, 0);
    // back to raw mode: pattern frozen
    add_row(0, 16'h0001, 16'hFFFF, 16'h4000, 1, -1, 0, 0, 0, 0, 0);
    add_row(0, 16'h8000, 16'h7FFF, 16'h8000, 1, -1, 0, 0, 0, 0, 0);
    add_row(0, 16'h0000, 16'h0000, 16'h0000, 1, 3, 0, 0, 0, 0, 0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    cfg_read(ADDR_ORIENT, rd);
    if (rd !== '0) report_mismatch($sformatf("orientation_mode after reset reads %0h", rd));

    foreach (plan[i]) begin
      r = plan[i];
      if (r.mode != orient_mode) apply_mode(r.mode);
      if (r.bnd >= 0) begin
        r.x = lim_x[r.bnd];
        r.y = lim_y[r.bnd];
      end
      issue_row(r);
    end

    // random phases: mostly steady-direction bursts that fill the window
    r.typed = 1'b0;
    r.bnd = -1;
    for (phase = 0; phase < 6; phase++) begin
      apply_mode(phase != 1 && phase != 4);
      r.mode = orient_mode;
      phase_start = items_sent;
      while (items_sent - phase_start < 200) begin
        kind = $urandom_range(0, 9);
        if (kind < 2) begin
          r.x = 16'($urandom);
          r.y = 16'($urandom);
          r.z = 16'($urandom);
          r.ok = ($urandom_range(0, 3) != 0);
          issue_row(r);
        end else begin
          if (kind < 4) begin
            k = $urandom_range(0, 7);
            bx = lim_x[k];
            by = lim_y[k];
          end else if (kind < 7) begin
            bx = 16'($urandom);
            by = 16'($urandom);
          end else if (kind < 9) begin
            bx = 16'($urandom_range(0, 255) - 128);
            by = 16'($urandom_range(0, 255) - 128);
          end else begin
            sel = $urandom_range(0, 2);
            bx = (sel == 1) ? 16'h0000 : 16'($urandom);
            by = (sel == 0) ? 16'h0000 : 16'($urandom);
            if (sel == 2) bx = 16'h0000;
          end
          reps = $urandom_range(4, 6);
          repeat (reps) begin
            r.ok = ($urandom_range(0, 6) != 0);
            r.x = r.ok ? bx : 16'($urandom);
            r.y = r.ok ? by : 16'($urandom);
            r.z = 16'($urandom);
            issue_row(r);
          end
        end
      end
    end

    in_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (pending_readings.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_readings.size()));

    $display("Run: %0d samples (%0d failed reads), %0d results checked, %0d mode writes",
             items_sent, failed_reads, results_seen, mode_writes);
    $display("Run: %0d headings on an exact sector limit, %0d mismatches",
             limit_hits, mismatches);
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

[sim.f]
sv/chf_pkg.sv
sv/chf_window.sv
sv/chf_cordic.sv
sv/compass_heading_filter.sv
dv/compass_heading_filter_test.sv
